FILE: rtl/core/oxygen_saturation_pixel_assert.svh
// Assertion macros shared by the oxygen saturation pixel RTL.
`ifndef OXYGEN_SATURATION_PIXEL_ASSERT_SVH
`define OXYGEN_SATURATION_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osp assertion failed");

`endif

FILE: rtl/core/osp_pkg.sv
// Shared widths, register indexes and the divider cell payload type.
`timescale 1ns / 1ps

package osp_pkg;

  localparam int IN_W            = 16;
  localparam int CFG_W           = 16;
  localparam int PCT_W           = 8;
  localparam int TOT_W           = IN_W + 1;
  localparam int SAT_W           = 16;
  localparam int IN_FRAC_BITS    = 8;
  localparam int RATIO_FRAC_BITS = 14;

  // Divider geometry: numerator is |oxy| << RATIO_FRAC_BITS.
  localparam int NUM_W    = IN_W + RATIO_FRAC_BITS;
  localparam int QUO_W    = SAT_W;
  localparam int NUM_HI_W = NUM_W - QUO_W;
  localparam int DEN_W    = TOT_W;
  localparam int REM_W    = DEN_W;

  // Threshold compare widths.
  localparam int THR_W     = CFG_W + IN_FRAC_BITS;
  localparam int PCT_CMP_W = PCT_W + RATIO_FRAC_BITS + 2;

  localparam int IN_DATA_W  = 2 * IN_W;
  localparam int OUT_DATA_W = ((SAT_W + TOT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HBO2_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HB_MIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT_MIN = 2'd3;

  // Payload handed from cell to cell. nq holds the numerator bits still to
  // be shifted in at the top and the quotient bits collected at the bottom.
  typedef struct packed {
    logic [REM_W-1:0]        rem;
    logic [DEN_W-1:0]        den;
    logic [QUO_W-1:0]        nq;
    logic                    neg;
    logic                    ovf;
    logic                    zero;
    logic                    thr_hit;
    logic signed [TOT_W-1:0] total;
  } div_t;

endpackage

FILE: rtl/core/osp_prep.sv
// Entry stage: sum, magnitudes, overflow check and hemoglobin thresholds.
`timescale 1ns / 1ps

module osp_prep (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic signed [osp_pkg::IN_W-1:0]    deoxy_i,
  input  logic signed [osp_pkg::IN_W-1:0]    oxy_i,
  input  logic signed [osp_pkg::CFG_W-1:0]   hbo2_min_i,
  input  logic signed [osp_pkg::CFG_W-1:0]   hb_min_i,
  input  logic signed [osp_pkg::CFG_W-1:0]   total_min_i,
  output logic                               vld_o,
  output osp_pkg::div_t                      div_o
);
  import osp_pkg::*;

  logic signed [TOT_W-1:0] total;
  logic        [TOT_W-1:0] oxy_neg;
  logic        [TOT_W:0]   tot_neg;
  logic        [IN_W-1:0]  oxy_mag;
  logic        [DEN_W-1:0] tot_mag;
  logic        [NUM_W-1:0] num;
  logic signed [THR_W:0]   hbo2_thr;
  logic signed [THR_W:0]   hb_thr;
  logic signed [THR_W:0]   tot_thr;
  logic signed [THR_W:0]   oxy_ext;
  logic signed [THR_W:0]   deoxy_ext;
  logic signed [THR_W:0]   tot_ext;
  logic                    hit_hbo2;
  logic                    hit_hb;
  logic                    hit_tot;
  div_t                    div_d;
  div_t                    div_q;
  logic                    vld_q;

  always_comb begin
    total   = {deoxy_i[IN_W-1], deoxy_i} + {oxy_i[IN_W-1], oxy_i};
    oxy_neg = -{oxy_i[IN_W-1], oxy_i};
    tot_neg = -{total[TOT_W-1], total};
    oxy_mag = oxy_i[IN_W-1] ? oxy_neg[IN_W-1:0] : oxy_i;
    tot_mag = total[TOT_W-1] ? tot_neg[DEN_W-1:0] : total;
    num     = {oxy_mag, {RATIO_FRAC_BITS{1'b0}}};

    // thresholds scaled to the input fixed point, compared one bit wider
    hbo2_thr  = {hbo2_min_i[CFG_W-1], hbo2_min_i, {IN_FRAC_BITS{1'b0}}};
    hb_thr    = {hb_min_i[CFG_W-1], hb_min_i, {IN_FRAC_BITS{1'b0}}};
    tot_thr   = {total_min_i[CFG_W-1], total_min_i, {IN_FRAC_BITS{1'b0}}};
    oxy_ext   = {{(THR_W + 1 - IN_W){oxy_i[IN_W-1]}}, oxy_i};
    deoxy_ext = {{(THR_W + 1 - IN_W){deoxy_i[IN_W-1]}}, deoxy_i};
    tot_ext   = {{(THR_W + 1 - TOT_W){total[TOT_W-1]}}, total};
    hit_hbo2  = (hbo2_min_i != '0) && (hbo2_thr > oxy_ext);
    hit_hb    = (hb_min_i != '0) && (hb_thr > deoxy_ext);
    hit_tot   = (total_min_i != '0) && (tot_thr > tot_ext);

    // Upper numerator bits give no quotient bit below 2^QUO_W unless the
    // quotient overflows, so they seed the remainder directly.
    div_d.rem     = REM_W'(num[NUM_W-1:QUO_W]);
    div_d.den     = tot_mag;
    div_d.nq      = num[QUO_W-1:0];
    div_d.neg     = oxy_i[IN_W-1] ^ total[TOT_W-1];
    div_d.ovf     = REM_W'(num[NUM_W-1:QUO_W]) >= tot_mag;
    div_d.zero    = (total == '0);
    div_d.thr_hit = hit_hbo2 | hit_hb | hit_tot;
    div_d.total   = total;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

FILE: rtl/core/osp_div_cell.sv
// One restoring divider cell: resolves one quotient bit per item.
`timescale 1ns / 1ps

module osp_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  osp_pkg::div_t div_i,
  output logic          vld_o,
  output osp_pkg::div_t div_o
);
  import osp_pkg::*;

  logic [REM_W:0]   shifted;
  logic [REM_W+1:0] diff;
  logic             take;
  div_t             div_d;
  div_t             div_q;
  logic             vld_q;

  always_comb begin
    shifted = {div_i.rem, div_i.nq[QUO_W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_i.den};
    take    = !diff[REM_W+1];

    div_d     = div_i;
    div_d.rem = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    div_d.nq  = {div_i.nq[QUO_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

FILE: rtl/core/osp_out.sv
// Output stage: sign and saturation of the ratio, percent threshold, result register.
`timescale 1ns / 1ps

module osp_out (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  osp_pkg::div_t                     div_i,
  input  logic [osp_pkg::PCT_W-1:0]         percent_min_i,
  output logic                              vld_o,
  output logic signed [osp_pkg::SAT_W-1:0]  sat_o,
  output logic signed [osp_pkg::TOT_W-1:0]  total_o,
  output logic                              zero_o,
  output logic                              supp_o
);
  import osp_pkg::*;

  localparam logic signed [PCT_CMP_W-1:0] PercentScale = PCT_CMP_W'(100);
  localparam logic signed [SAT_W-1:0]     SatMax = {1'b0, {(SAT_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0]     SatMin = {1'b1, {(SAT_W - 1){1'b0}}};

  logic        [QUO_W-1:0]     quo;
  logic signed [SAT_W-1:0]     ratio;
  logic signed [PCT_CMP_W-1:0] ratio_ext;
  logic signed [PCT_CMP_W-1:0] pct_val;
  logic signed [PCT_CMP_W-1:0] pct_thr;
  logic                        hit_pct;
  logic                        supp;
  logic                        vld_q;
  logic signed [SAT_W-1:0]     sat_q;
  logic signed [TOT_W-1:0]     total_q;
  logic                        zero_q;
  logic                        supp_q;

  always_comb begin
    quo = div_i.nq;
    if (!div_i.neg) begin
      ratio = (div_i.ovf || quo[QUO_W-1]) ? SatMax : quo;
    end else begin
      // magnitude of exactly 2^(QUO_W-1) still fits as the most negative code
      ratio = (div_i.ovf || (quo[QUO_W-1] && (quo[QUO_W-2:0] != '0))) ? SatMin : -quo;
    end

    ratio_ext = {{(PCT_CMP_W - SAT_W){ratio[SAT_W-1]}}, ratio};
    pct_val   = ratio_ext * PercentScale;
    pct_thr   = {{(PCT_CMP_W - PCT_W - RATIO_FRAC_BITS){1'b0}}, percent_min_i,
                 {RATIO_FRAC_BITS{1'b0}}};
    hit_pct   = (percent_min_i != '0) && (pct_thr > pct_val);
    supp      = !div_i.zero && (div_i.thr_hit || hit_pct);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q   <= (div_i.zero || supp) ? '0 : ratio;
      total_q <= div_i.total;
      zero_q  <= div_i.zero;
      supp_q  <= supp;
    end
  end

  assign vld_o   = vld_q;
  assign sat_o   = sat_q;
  assign total_o = total_q;
  assign zero_o  = zero_q;
  assign supp_o  = supp_q;

endmodule

FILE: rtl/core/oxygen_saturation_pixel.sv
// Top level of the per-voxel oxygen saturation pipeline.
`timescale 1ns / 1ps
`include "oxygen_saturation_pixel_assert.svh"

// Per-voxel oxygen saturation. Each input item carries one voxel's deoxy- and
// oxyhemoglobin values (signed Q8.8); each result item gives the total
// hemoglobin (exact sum, Q9.8), the saturation oxy/total as signed Q2.14
// (truncated toward zero, clipped to the 16-bit range), a zero-sum flag and a
// suppressed flag. A zero total yields saturation 0 with zero_sum set and no
// threshold check. Four thresholds (oxy, deoxy, total in whole units, and
// saturation in percent; 0 disables each) force saturation to 0 and set
// suppressed when any enabled one is strictly above its value. Throughput is
// one item per clock while results are taken; an item passes from acceptance
// to the master side through one entry stage, a chain of 16 divider cells
// that each resolve one quotient bit, and the output register. The pipeline
// advances as a whole whenever the output register is empty or being taken,
// so s_axis_tready_o follows m_axis_tready_i when a result is waiting.
// Thresholds are taken through the configuration channel, which is always
// ready; registers must only be written while no items are in flight.

module oxygen_saturation_pixel (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [osp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [osp_pkg::CFG_W-1:0]          cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: [15:0] deoxy_value, [31:16] oxy_value
  input  logic [osp_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: [15:0] saturation, [32:16] total_hemoglobin, [39:33] zero
  output logic [osp_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // tuser: [0] zero_sum, [1] suppressed
  output logic [osp_pkg::OUT_USER_W-1:0]     m_axis_tuser_o
);
  import osp_pkg::*;

  logic signed [CFG_W-1:0] hbo2_min_q;
  logic signed [CFG_W-1:0] hb_min_q;
  logic signed [CFG_W-1:0] total_min_q;
  logic [PCT_W-1:0]        percent_min_q;

  logic                    adv;
  logic [QUO_W:0]          vld;
  div_t                    div [QUO_W+1];
  logic                    out_vld;
  logic signed [SAT_W-1:0] sat;
  logic signed [TOT_W-1:0] total;
  logic                    zero_sum;
  logic                    suppressed;
  logic [QUO_W+1:0]        vld_all;

  // ---------------------------------------------------------------------
  // Configuration registers; unknown indexes are dropped.
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hbo2_min_q    <= '0;
      hb_min_q      <= '0;
      total_min_q   <= '0;
      percent_min_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HBO2_MIN:    hbo2_min_q    <= cfg_data_i;
        REG_HB_MIN:      hb_min_q      <= cfg_data_i;
        REG_TOTAL_MIN:   total_min_q   <= cfg_data_i;
        REG_PERCENT_MIN: percent_min_q <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline: the whole chain moves when the output register can take an item.
  // ---------------------------------------------------------------------
  assign adv             = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  osp_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .vld_i       (s_axis_tvalid_i),
    .deoxy_i     (s_axis_tdata_i[IN_W-1:0]),
    .oxy_i       (s_axis_tdata_i[IN_DATA_W-1:IN_W]),
    .hbo2_min_i  (hbo2_min_q),
    .hb_min_i    (hb_min_q),
    .total_min_i (total_min_q),
    .vld_o       (vld[0]),
    .div_o       (div[0])
  );

  // one cell per quotient bit, most significant first
  for (genvar g = 0; g < QUO_W; g++) begin : g_cell
    osp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (vld[g]),
      .div_i  (div[g]),
      .vld_o  (vld[g+1]),
      .div_o  (div[g+1])
    );
  end

  osp_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .vld_i         (vld[QUO_W]),
    .div_i         (div[QUO_W]),
    .percent_min_i (percent_min_q),
    .vld_o         (out_vld),
    .sat_o         (sat),
    .total_o       (total),
    .zero_o        (zero_sum),
    .supp_o        (suppressed)
  );

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - SAT_W - TOT_W){1'b0}}, total, sat};
  assign m_axis_tuser_o  = {suppressed, zero_sum};

  assign vld_all = {out_vld, vld};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `OSP_ASSERT_NEXT(a_stall_freezes_pipe, clk_i, rst_ni, !adv, $stable(vld_all))
  `OSP_ASSERT_IMPLY(a_zero_clears_result, clk_i, rst_ni, out_vld && zero_sum,
                    (sat == '0) && !suppressed && (total == '0))
  `OSP_ASSERT_IMPLY(a_supp_clears_sat, clk_i, rst_ni, out_vld && suppressed,
                    (sat == '0) && !zero_sum)
  `OSP_ASSERT_IMPLY(a_nonzero_total_flag, clk_i, rst_ni, out_vld && !zero_sum,
                    total != '0)

endmodule
